FILE: design/transposed_matrix_vector_mac_defines.svh
// ---------------------------------------------------------------------------
// Transposed matrix-vector MAC assertion macros
// Shared property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef TRANSPOSED_MATRIX_VECTOR_MAC_DEFINES_SVH
`define TRANSPOSED_MATRIX_VECTOR_MAC_DEFINES_SVH

// same-cycle implication, masked during reset
`define TMV_ASSERT_NOW(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (cons)) \
        else $error("tmv assertion failed");

// next-cycle implication, masked during reset
`define TMV_ASSERT_NEXT(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (cons)) \
        else $error("tmv assertion failed");

// next-cycle implication, active through reset
`define TMV_ASSERT_RST(lbl, clk, ant, cons) \
    lbl: assert property (@(posedge clk) (ant) |=> (cons)) \
        else $error("tmv assertion failed");

`endif

FILE: design/tmv_pkg.sv
// ---------------------------------------------------------------------------
// Transposed matrix-vector MAC package
// Field widths, the reset length and the position flags passed from the sequencer.
// ---------------------------------------------------------------------------
package tmv_pkg;

    localparam int DATA_W = 32;
    localparam int VL_W   = 13;
    localparam int IDX_W  = 12;
    localparam int VL_RST = 4096;

    typedef struct packed {
        logic first_row;
        logic last_row;
        logic last_col;
    } pos_flags_t;

endpackage

FILE: design/tmv_ctr.sv
// ---------------------------------------------------------------------------
// Transposed matrix-vector MAC row/column sequencer
// Tracks the row and column of the next request and flags row boundaries.
// ---------------------------------------------------------------------------
module tmv_ctr #(
    parameter int MAX_N = 4096,
    parameter int CW    = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [tmv_pkg::VL_W-1:0]  cfg_length,
    input  logic                      step,
    output logic [CW-1:0]             col,
    output tmv_pkg::pos_flags_t       flags
);
    import tmv_pkg::*;

    localparam int NRST = (VL_RST > MAX_N) ? MAX_N : VL_RST;

    logic [CW-1:0] nm1_reg, nm1_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [31:0]   n_wide;

    always_comb begin
        n_wide = 32'(cfg_length);
        if (n_wide == 32'd0) begin
            n_wide = 32'd1;
        end
        if (n_wide > 32'(MAX_N)) begin
            n_wide = 32'(MAX_N);
        end
        nm1_next = CW'(n_wide - 32'd1);
    end

    assign col             = col_reg;
    assign flags.first_row = (row_reg == '0);
    assign flags.last_row  = (row_reg == nm1_reg);
    assign flags.last_col  = (col_reg == nm1_reg);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (step) begin
            if (flags.last_col) begin
                col_next = '0;
                row_next = flags.last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nm1_reg <= CW'(NRST - 1);
            row_reg <= '0;
            col_reg <= '0;
        end else if (cfg_we) begin
            nm1_reg <= nm1_next;
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

FILE: design/transposed_matrix_vector_mac.sv
// Three register stages (stage 1, stage 2, output register) from the accepting edge to m_valid.
// Throughput: one request per cycle; the whole pipe advances whenever the output
// register is empty or being drained, so m_ready sets the pace.
// Reset clears counters, valid bits and the length (4096, capped at MAX_N);
// both readies are low while reset is held.
// Accumulator memory is not cleared: the first row overwrites it.
// ---------------------------------------------------------------------------
// Transposed matrix-vector MAC
// Streams a row-major matrix with its vector and emits column dot products.
// ---------------------------------------------------------------------------
module transposed_matrix_vector_mac #(
    parameter int MAX_N = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tmv_pkg::VL_W-1:0]    cfg_vector_length,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tmv_pkg::DATA_W-1:0]  s_mat_elem,
    input  logic [tmv_pkg::DATA_W-1:0]  s_vec_elem,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tmv_pkg::IDX_W-1:0]   m_result_index,
    output logic [tmv_pkg::DATA_W-1:0]  m_result_value,
    output logic                        m_last_result
);
    import tmv_pkg::*;

    localparam int CW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    logic              adv;
    logic              s_take;
    logic [CW-1:0]     seq_col;
    pos_flags_t        seq_flags;

    // stage 1: operands and position
    logic              p1_valid_reg;
    logic [DATA_W-1:0] p1_mat_reg;
    logic [DATA_W-1:0] p1_vec_reg;
    logic [CW-1:0]     p1_col_reg;
    pos_flags_t        p1_flags_reg;

    // stage 2: product, accumulator read data
    logic              p2_valid_reg;
    logic [DATA_W-1:0] p2_prod_reg;
    logic [CW-1:0]     p2_col_reg;
    pos_flags_t        p2_flags_reg;
    logic              p2_fwd_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic [DATA_W-1:0] rd_data_reg;

    // output register
    logic              m_valid_reg;
    logic [IDX_W-1:0]  m_index_reg;
    logic [DATA_W-1:0] m_value_reg;
    logic              m_last_reg;

    logic [DATA_W-1:0] acc_mem [MAX_N];

    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] acc_old;
    logic [DATA_W-1:0] acc_sum;
    logic [31:0]       col_wide;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv && aresetn;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = aresetn;

    tmv_ctr #(
        .MAX_N (MAX_N),
        .CW    (CW)
    ) u_ctr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid),
        .cfg_length (cfg_vector_length),
        .step       (s_take),
        .col        (seq_col),
        .flags      (seq_flags)
    );

    assign prod     = p1_mat_reg * p1_vec_reg;
    assign acc_old  = p2_fwd_reg ? fwd_data_reg : rd_data_reg;
    assign acc_sum  = p2_flags_reg.first_row ? p2_prod_reg : acc_old + p2_prod_reg;
    assign col_wide = 32'(p2_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= s_valid;
            p2_valid_reg <= p1_valid_reg;
            m_valid_reg  <= p2_valid_reg && p2_flags_reg.last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_mat_reg   <= s_mat_elem;
            p1_vec_reg   <= s_vec_elem;
            p1_col_reg   <= seq_col;
            p1_flags_reg <= seq_flags;
            p2_prod_reg  <= prod;
            p2_col_reg   <= p1_col_reg;
            p2_flags_reg <= p1_flags_reg;
            // same column written on this edge: memory read misses it
            p2_fwd_reg   <= p2_valid_reg && (p2_col_reg == p1_col_reg);
            fwd_data_reg <= acc_sum;
            m_index_reg  <= col_wide[IDX_W-1:0];
            m_value_reg  <= acc_sum;
            m_last_reg   <= p2_flags_reg.last_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_data_reg <= acc_mem[p1_col_reg];
            if (p2_valid_reg) begin
                acc_mem[p2_col_reg] <= acc_sum;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_index = m_index_reg;
    assign m_result_value = m_value_reg;
    assign m_last_result  = m_last_reg;

endmodule

FILE: design/tmv_chk.sv
// ---------------------------------------------------------------------------
// Transposed matrix-vector MAC port checker
// Watches the top-level handshakes over time; bound to the top level.
// ---------------------------------------------------------------------------
`include "transposed_matrix_vector_mac_defines.svh"

module tmv_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [11:0] m_result_index,
    input  logic [31:0] m_result_value,
    input  logic        m_last_result
);

    `TMV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_value) && $stable(m_result_index) && $stable(m_last_result))

    `TMV_ASSERT_NOW(a_in_ready, aclk, aresetn, !m_valid || m_ready, s_ready)

    `TMV_ASSERT_NOW(a_cfg_ready, aclk, aresetn, cfg_valid, cfg_ready)

    `TMV_ASSERT_RST(a_rst_quiet, aclk, !aresetn, !m_valid)

endmodule

bind transposed_matrix_vector_mac tmv_chk u_tmv_chk (.*);

FILE: tb/tb_transposed_matrix_vector_mac.sv
// ---------------------------------------------------------------------------
// Transposed matrix-vector MAC testbench
// Streams row-major matrices with their vector elements through the block,
// predicts every column dot product (mod 2^32) and checks each result
// against it in order. The length register is changed between phases,
// including zero, the reset value and oversized lengths. Both handshakes
// stall at random.
// ---------------------------------------------------------------------------
module tb_transposed_matrix_vector_mac;

    localparam int MAX_N        = 4096;
    localparam int TOTAL_ITEMS  = 1870;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [tmv_pkg::DATA_W-1:0] mat;
        logic [tmv_pkg::DATA_W-1:0] vec;
    } mac_req_t;

    typedef struct {
        logic [tmv_pkg::IDX_W-1:0]  idx;
        logic [tmv_pkg::DATA_W-1:0] sum;
        logic                       last;
    } column_sum_t;

    logic                       aclk;
    logic                       aresetn           = 1'b0;
    logic                       cfg_valid         = 1'b0;
    logic                       cfg_ready;
    logic [tmv_pkg::VL_W-1:0]   cfg_vector_length = '0;
    logic                       s_valid           = 1'b0;
    logic                       s_ready;
    logic [tmv_pkg::DATA_W-1:0] s_mat_elem        = '0;
    logic [tmv_pkg::DATA_W-1:0] s_vec_elem        = '0;
    logic                       m_valid;
    logic                       m_ready           = 1'b0;
    logic [tmv_pkg::IDX_W-1:0]  m_result_index;
    logic [tmv_pkg::DATA_W-1:0] m_result_value;
    logic                       m_last_result;

    // predictor state
    logic [tmv_pkg::DATA_W-1:0] col_sums [0:MAX_N-1];
    logic [tmv_pkg::VL_W-1:0]   len_reg = tmv_pkg::VL_W'(tmv_pkg::VL_RST);
    int unsigned                row_ptr = 0;
    int unsigned                col_ptr = 0;

    mac_req_t    req_queue[$];
    column_sum_t expected_sums[$];
    int unsigned reqs_sent  = 0;
    int unsigned reqs_taken = 0;
    int unsigned errors     = 0;
    int unsigned cyc_count  = 0;
    int          src_wait   = 0;
    int          sink_wait  = 0;

    transposed_matrix_vector_mac #(
        .MAX_N(MAX_N)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_vector_length (cfg_vector_length),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mat_elem        (s_mat_elem),
        .s_vec_elem        (s_vec_elem),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_index    (m_result_index),
        .m_result_value    (m_result_value),
        .m_last_result     (m_last_result)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc_count++;
    end

    initial begin
        while (cyc_count < CYCLE_LIMIT) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned eff_len(input logic [tmv_pkg::VL_W-1:0] len);
        if (len == 0) return 1;
        if (len > MAX_N) return MAX_N;
        return 32'(len);
    endfunction

    // recurring idle-free windows, random waits otherwise
    function automatic int draw_wait();
        if ((cyc_count / 400) % 3 == 0) return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [tmv_pkg::DATA_W-1:0] draw_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    function automatic void predict_column_sum(input logic [tmv_pkg::DATA_W-1:0] mat,
                                               input logic [tmv_pkg::DATA_W-1:0] vec);
        int unsigned                n;
        logic [tmv_pkg::DATA_W-1:0] prod;
        logic [tmv_pkg::DATA_W-1:0] acc;
        column_sum_t                res;
        n = eff_len(len_reg);
        if (col_ptr >= n) col_ptr = 0;
        if (row_ptr >= n) row_ptr = 0;
        prod = mat * vec;
        acc  = (row_ptr == 0) ? prod : col_sums[col_ptr] + prod;
        col_sums[col_ptr] = acc;
        if (row_ptr == n - 1) begin
            res.idx  = col_ptr[tmv_pkg::IDX_W-1:0];
            res.sum  = acc;
            res.last = (col_ptr == n - 1);
            expected_sums.push_back(res);
        end
        col_ptr++;
        if (col_ptr >= n) begin
            col_ptr = 0;
            row_ptr++;
            if (row_ptr >= n) row_ptr = 0;
        end
    endfunction

    task automatic send(input logic [tmv_pkg::DATA_W-1:0] mat,
                        input logic [tmv_pkg::DATA_W-1:0] vec);
        mac_req_t r;
        r.mat = mat;
        r.vec = vec;
        req_queue.push_back(r);
        reqs_sent++;
    endtask

    // wait for every request to be taken and every sum to come out
    task automatic wait_drained();
        while (reqs_taken != reqs_sent || expected_sums.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_length(input logic [tmv_pkg::VL_W-1:0] len);
        @(posedge aclk);
        cfg_vector_length <= len;
        cfg_valid         <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        len_reg = len;
        row_ptr = 0;
        col_ptr = 0;
    endtask

    // request driver
    always @(posedge aclk) begin
        mac_req_t nxt;
        logic     drive;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            src_wait = 0;
        end else begin
            drive = s_valid;
            if (s_valid && s_ready) begin
                predict_column_sum(s_mat_elem, s_vec_elem);
                reqs_taken++;
                drive    = 1'b0;
                src_wait = draw_wait();
            end
            if (!drive) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (req_queue.size() != 0) begin
                    nxt = req_queue.pop_front();
                    s_mat_elem <= nxt.mat;
                    s_vec_elem <= nxt.vec;
                    drive = 1'b1;
                end
            end
            s_valid <= drive;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        column_sum_t want;
        logic        rdy;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait = 0;
        end else begin
            rdy = m_ready;
            if (m_valid && m_ready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected result idx %0d value %h last %b", $time,
                             m_result_index, m_result_value, m_last_result);
                    errors++;
                end else begin
                    want = expected_sums.pop_front();
                    if (m_result_index !== want.idx || m_result_value !== want.sum ||
                        m_last_result !== want.last) begin
                        $display({"%0t: mismatch exp idx %0d value %h last %b, ",
                                  "got idx %0d value %h last %b"},
                                 $time, want.idx, want.sum, want.last,
                                 m_result_index, m_result_value, m_last_result);
                        errors++;
                    end
                end
                rdy       = 1'b0;
                sink_wait = draw_wait();
            end
            if (!rdy) begin
                if (sink_wait > 0) sink_wait--;
                else rdy = 1'b1;
            end
            m_ready <= rdy;
        end
    end

    initial begin
        logic [tmv_pkg::VL_W-1:0]   len;
        logic [tmv_pkg::DATA_W-1:0] row_vec;
        int unsigned                n;
        int unsigned                count;
        int unsigned                pick;
        logic                       per_row;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset length: part of the first row only, no sums due
        send('1, '1);
        send('0, '1);
        send('1, '0);
        wait_drained();

        // single-element matrix, every request is a finished sum
        write_length(1);
        send('0, '0);
        send('1, '1);
        send('1, 32'd1);
        send(32'h8000_0000, 32'd2);
        send(32'h0001_0000, 32'h0001_0000);
        wait_drained();

        // zero length behaves as one
        write_length(0);
        send(32'd7, 32'd9);
        send('1, 32'h8000_0001);
        wait_drained();

        // oversized length saturates
        write_length('1);
        send(32'd3, 32'd5);
        send('1, '1);
        wait_drained();

        // 2x2 with wrapping sums, then a partial product cut by a length write
        write_length(2);
        send('1, '1);
        send('1, '1);
        send('1, '1);
        send(32'd1, '1);
        send(32'hdead_beef, 32'd3);
        send(32'h1234_5678, 32'd3);
        wait_drained();

        while (reqs_sent < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                case ($urandom_range(0, 3))
                    0: len = '0;
                    1: len = tmv_pkg::VL_W'(MAX_N);
                    2: len = '1;
                    default: len = tmv_pkg::VL_W'($urandom_range(MAX_N + 1, 8191));
                endcase
            end else if (pick < 4) begin
                len = tmv_pkg::VL_W'($urandom_range(9, 24));
            end else begin
                len = tmv_pkg::VL_W'($urandom_range(1, 8));
            end
            write_length(len);
            n = eff_len(len);
            if (n > 24) begin
                count = $urandom_range(1, 20);
            end else begin
                count = (n > 12) ? n * n : n * n * $urandom_range(1, 3);
                if (n > 1 && $urandom_range(0, 3) == 0)
                    count += $urandom_range(1, n * n - 1);
            end
            if (count > TOTAL_ITEMS - reqs_sent) count = TOTAL_ITEMS - reqs_sent;
            per_row = ($urandom_range(0, 3) != 0);
            row_vec = draw_word();
            for (int unsigned i = 0; i < count; i++) begin
                if (i % n == 0) row_vec = draw_word();
                send(draw_word(), per_row ? row_vec : draw_word());
            end
            wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0 && expected_sums.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
